@@ rtl/circular_array_deque_assert.svh @@
// Assertion macros used by the deque top level.
// Depends on a clock named clk and a synchronous reset named rst in the including module.
`ifndef CIRCULAR_ARRAY_DEQUE_ASSERT_SVH
`define CIRCULAR_ARRAY_DEQUE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define CAD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define CAD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/cad_pkg.sv @@
// Shared types and constants for the circular array deque.
// No dependencies; used by cad_cell and circular_array_deque.
package cad_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CapWidth  = 5;

  localparam logic [DataWidth-1:0] EmptyValue = '1;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  // Status codes returned with each result.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;       // Drop all elements.
    logic shift_in;    // Push at the front: everything moves one cell toward the rear.
    logic append;      // Push at the rear: the first free cell takes the value.
    logic shift_out;   // Pop at the front: everything moves one cell toward the front.
    logic drop_rear;   // Pop at the rear: the last occupied cell is freed.
  } cell_ctl_t;

endpackage

@@ rtl/circular_array_deque.sv @@
// Top level of the circular array deque: request decode, cell chain, result stage, APB port.
// Depends on cad_pkg, cad_cell and circular_array_deque_assert.svh.
//
// Usage: a request is taken at a rising clock edge where start is high and busy is low.
// The request is req_type (push front, push rear, pop front, pop rear) with push_value.
// busy is always low, so one request can be issued in every cycle.
// In the cycle after the request is taken, done is high for one cycle and status,
// front_value, rear_value, is_empty and is_full describe the deque after that request.
// Throughput is one item per cycle: the element storage is a
// row of cells that all shift or load in the same cycle, so no request holds busy high.
// The front element always sits in the first cell and the occupied cells form a
// contiguous run; the rear element is the last occupied cell.
// The receiver cannot stall; each result is shown for exactly one cycle.
// A push into a full deque reports overflow and a pop from an empty one reports
// underflow; neither changes the contents. Value outputs read all ones when empty.
// The capacity register (APB address 0) limits how many elements are held; zero acts
// as one and values above DEPTH act as DEPTH. Writing it empties the deque.
// Reset empties the deque, sets capacity to 16 and drops any pending result.
module circular_array_deque
  import cad_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // Request channel.
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic signed [DataWidth-1:0] push_value,
  // Result channel.
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [DataWidth-1:0] front_value,
  output logic signed [DataWidth-1:0] rear_value,
  output logic                        is_empty,
  output logic                        is_full,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);
  localparam int unsigned CmpWidth = (CntWidth > CapWidth) ? CntWidth : CapWidth;
  localparam logic [CapWidth-1:0] CapReset = CapWidth'(16);
  localparam logic [1:0] CapAddr = 2'd0;

  // Configuration register.
  logic [CapWidth-1:0] capacity;
  logic                cfg_wr;
  logic [CntWidth-1:0] eff_cap;

  // Element count, kept alongside the cells so full needs only one compare.
  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] count_next;

  // Result stage.
  status_t status_q;
  status_t status_next;
  logic    done_q;

  // Cell chain.
  cell_ctl_t            ctl;
  logic [DataWidth-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DataWidth-1:0] lval [DEPTH];
  logic [DataWidth-1:0] rval [DEPTH];
  logic [DEPTH-1:0]     lvld;
  logic [DEPTH-1:0]     rvld;
  logic [DataWidth-1:0] rear_sel;

  logic accept;
  logic is_full_now;
  logic is_empty_now;
  req_t req;

  assign pready = 1'b1;
  assign prdata = {{(32 - CapWidth){1'b0}}, capacity};
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == CapAddr);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg_wr) begin
      capacity <= pwdata[CapWidth-1:0];
    end
  end

  // Clamp the programmed capacity into 1..DEPTH.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CntWidth'(1);
    end else if (CmpWidth'(capacity) > CmpWidth'(DEPTH)) begin
      eff_cap = CntWidth'(DEPTH);
    end else begin
      eff_cap = CntWidth'(capacity);
    end
  end

  assign busy         = 1'b0;
  assign accept       = start && !busy;
  assign req          = req_t'(req_type);
  assign is_empty_now = !cell_valid[0];
  assign is_full_now  = (count == eff_cap);

  // Decode the request into one chain command and the next count and status.
  always_comb begin
    ctl         = '0;
    count_next  = count;
    status_next = ST_DONE;
    if (cfg_wr) begin
      ctl.clear  = 1'b1;
      count_next = '0;
    end else if (accept) begin
      unique case (req) inside
        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
          if (is_full_now) begin
            status_next = ST_OVERFLOW;
          end else begin
            // Into an empty deque both kinds of push just fill the front cell.
            ctl.shift_in = (req == REQ_PUSH_FRONT);
            ctl.append   = (req == REQ_PUSH_REAR);
            count_next   = count + CntWidth'(1);
          end
        end
        REQ_POP_FRONT, REQ_POP_REAR: begin
          if (is_empty_now) begin
            status_next = ST_UNDERFLOW;
          end else begin
            ctl.shift_out = (req == REQ_POP_FRONT);
            ctl.drop_rear = (req == REQ_POP_REAR);
            count_next    = count - CntWidth'(1);
          end
        end
        default: begin
          status_next = ST_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      count  <= count_next;
      done_q <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
    end
  end

  // Neighbor wiring: the front cell sees the incoming value on its left, and the rear
  // end of the row sees an empty cell on its right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lval[i] = push_value;
      assign lvld[i] = 1'b1;
    end else begin : g_mid
      assign lval[i] = cell_value[i-1];
      assign lvld[i] = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rval[i] = '0;
      assign rvld[i] = 1'b0;
    end else begin : g_inner
      assign rval[i] = cell_value[i+1];
      assign rvld[i] = cell_valid[i+1];
    end

    cad_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .din         (push_value),
      .left_value  (lval[i]),
      .left_valid  (lvld[i]),
      .right_value (rval[i]),
      .right_valid (rvld[i]),
      .value       (cell_value[i]),
      .valid       (cell_valid[i])
    );
  end

  // The rear is the one occupied cell whose right neighbor is free.
  always_comb begin
    rear_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_valid[i] && !rvld[i]) begin
        rear_sel = rear_sel | cell_value[i];
      end
    end
  end

  assign done        = done_q;
  assign status      = status_q;
  assign front_value = is_empty_now ? EmptyValue : cell_value[0];
  assign rear_value  = is_empty_now ? EmptyValue : rear_sel;
  assign is_empty    = is_empty_now;
  assign is_full     = is_full_now;

`include "circular_array_deque_assert.svh"

  `CAD_ASSERT_ALWAYS(a_count_matches_cells, (count == '0) == !cell_valid[0], "count and cell occupancy disagree")
  `CAD_ASSERT_IMP(a_underflow_only_empty, done && (status == ST_UNDERFLOW), $past(count) == '0, "underflow reported on a non-empty deque")
  `CAD_ASSERT_IMP(a_overflow_keeps_count, done && (status == ST_OVERFLOW) && !$past(cfg_wr), count == $past(count), "overflow changed the deque")
  `CAD_ASSERT_IMP(a_count_in_range, !cfg_wr, count <= eff_cap, "count exceeds capacity")

endmodule

@@ rtl/cad_cell.sv @@
// One storage cell of the deque chain: an element and its occupied bit.
// Depends on cad_pkg; instantiated in a row by circular_array_deque.
module cad_cell
  import cad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [DataWidth-1:0] din,
  input  logic [DataWidth-1:0] left_value,
  input  logic                 left_valid,
  input  logic [DataWidth-1:0] right_value,
  input  logic                 right_valid,
  output logic [DataWidth-1:0] value,
  output logic                 valid
);

  // Occupied cells always form a contiguous run from the front cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift_in) begin
      valid <= left_valid;
    end else if (ctl.append) begin
      valid <= valid | left_valid;
    end else if (ctl.shift_out) begin
      valid <= right_valid;
    end else if (ctl.drop_rear) begin
      valid <= valid & right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      value <= left_value;
    end else if (ctl.append && !valid && left_valid) begin
      value <= din;
    end else if (ctl.shift_out) begin
      value <= right_value;
    end
  end

endmodule
